FILE: design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with delete.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int KIND_W   = 3;
  localparam int OCC_W    = 5;
  // count must hold CAPACITY itself
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_POP_BACK   = 3'd1,
    KIND_PUSH_FRONT = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_DELETE     = 3'd4,
    KIND_COUNT      = 3'd5
  } kind_t;

  // broadcast to every cell in the row
  typedef struct packed {
    kind_t             kind;
    logic              full;
    logic [VAL_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/bounded_deque_with_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_delete
// Bounded double-ended queue of signed values with delete by value.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. busy
//   stays low: every request completes in the cycle it is taken, so a new
//   one may follow on every cycle.
//   in_kind selects push back, pop back, push front, pop front, delete or
//   count; in_value is the value to push or delete.
//   Exactly one result follows each request, in the cycle after it is taken,
//   with out_valid high for that single cycle. The receiver cannot stall.
//   Throughput 1 request per cycle; the row of cells compares and shifts
//   all slots in parallel, and the first-match chain through the row sets
//   the longest path.
//   Pops on an empty queue return 0 with out_was_empty; pushes onto a full
//   queue are dropped with out_overflowed; out_match_found marks a delete
//   that removed an entry. out_occupancy is the entry count afterwards.
//   Reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_delete
  import bdq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic signed [VAL_W-1:0] in_value,
  output      logic              out_valid,
  output      logic signed [VAL_W-1:0] out_popped_value,
  output      logic [OCC_W-1:0]  out_occupancy,
  output      logic              out_was_empty,
  output      logic              out_overflowed,
  output      logic              out_match_found
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             valid_r;
  logic [VAL_W-1:0] popped_r, popped_nxt;
  logic             empty_r, empty_nxt;
  logic             over_r, over_nxt;
  logic             found_r, found_nxt;

  cell_ctrl_t       ctrl;
  logic             take;
  logic             full;
  logic             empty;
  logic             found;
  logic [VAL_W-1:0] back_val;

  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [VAL_W-1:0] tap      [CAPACITY];
  logic             hit      [CAPACITY+1];

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // idle cycles present a count request so the row holds still
  always_comb begin
    ctrl.kind  = take ? kind_t'(in_kind) : KIND_COUNT;
    ctrl.full  = full;
    ctrl.value = in_value;
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             occ;
    logic             is_next;
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;

    assign occ     = (CNT_W'(i) < count_r);
    assign is_next = (CNT_W'(i) == count_r);
    // slot holding the back entry drives its value onto the pop-back bus
    assign tap[i]  = (CNT_W'(i + 1) == count_r) ? cell_val[i] : '0;

    if (i == 0) begin : g_first
      assign left_val = ctrl.value;
    end else begin : g_inner
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    bdq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ),
      .is_next   (is_next),
      .left_val  (left_val),
      .right_val (right_val),
      .hit_in    (hit[i]),
      .hit_out   (hit[i+1]),
      .val_q     (cell_val[i])
    );
  end

  assign found = hit[CAPACITY];

  always_comb begin
    back_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_val = back_val | tap[i];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    empty_nxt  = 1'b0;
    over_nxt   = 1'b0;
    found_nxt  = 1'b0;
    case (ctrl.kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (full) over_nxt  = 1'b1;
        else      count_nxt = count_r + CNT_W'(1);
      end
      KIND_POP_BACK: begin
        if (empty) begin
          empty_nxt = 1'b1;
        end else begin
          popped_nxt = back_val;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          empty_nxt = 1'b1;
        end else begin
          popped_nxt = cell_val[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        if (found) begin
          found_nxt = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    empty_r  <= empty_nxt;
    over_r   <= over_nxt;
    found_r  <= found_nxt;
  end

  assign out_valid        = valid_r;
  assign out_popped_value = popped_r;
  assign out_occupancy    = OCC_W'(count_r);
  assign out_was_empty    = empty_r;
  assign out_overflowed   = over_r;
  assign out_match_found  = found_r;

endmodule

`default_nettype wire

FILE: design/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage slot of the deque row. Holds one value and moves it to or
// from its neighbours as the broadcast request dictates.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell
  import bdq_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic             occ,        // slot holds a live entry
  input  wire logic             is_next,    // first free slot
  input  wire logic [VAL_W-1:0] left_val,   // neighbour towards the front
  input  wire logic [VAL_W-1:0] right_val,  // neighbour towards the back
  input  wire logic             hit_in,     // a match exists further front
  output      logic             hit_out,
  output      logic [VAL_W-1:0] val_q
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             match;

  assign match   = occ && (val_r == ctrl.value);
  assign hit_out = hit_in || match;
  assign val_q   = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.kind)
      KIND_PUSH_BACK: begin
        if (is_next) val_nxt = ctrl.value;
      end
      KIND_PUSH_FRONT: begin
        if (!ctrl.full && (occ || is_next)) val_nxt = left_val;
      end
      KIND_POP_FRONT: begin
        if (occ) val_nxt = right_val;
      end
      KIND_DELETE: begin
        // close the gap from the first match onwards
        if (occ && hit_out) val_nxt = right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire
